>>> hw/rtl/ttom_pkg.sv
// Types, constants and the micro-program shared by the tour move block.
`timescale 1ns / 1ps

package ttom_pkg;

    localparam int CITIES = 64;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int PC_W   = 7;

    typedef logic [IDX_W-1:0] city_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [PC_W-1:0]  pc_t;

    typedef enum logic [1:0] {
        FN_WRITE     = 2'd0,
        FN_TWO_OPT   = 2'd1,
        FN_THREE_OPT = 2'd2,
        FN_READ      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        VAR_CASE0 = 2'd0,
        VAR_CASE1 = 2'd1,
        VAR_CASE2 = 2'd2,
        VAR_CASE3 = 2'd3
    } variant_t;

    typedef struct packed {
        logic [1:0] func;
        city_t      city;
        city_t      next_city;
        logic [5:0] hops;
        city_t      third_city;
        logic [1:0] variant;
    } req_item_t;

    typedef struct packed {
        logic  status;
        city_t succ_out;
        city_t pred_out;
    } rsp_item_t;

    // Micro-operations of the sequencer
    typedef enum logic [3:0] {
        OP_WRITE,
        OP_NX,
        OP_PR,
        OP_PUT,
        OP_HOP,
        OP_RELINK,
        OP_DIST,
        OP_CHECK,
        OP_ORDER,
        OP_REBUILD,
        OP_DONE
    } op_t;

    // Working registers of the datapath
    typedef enum logic [2:0] {
        R_C1,
        R_C2,
        R_C3,
        R_A,
        R_B,
        R_C,
        R_T,
        R_X
    } reg_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t dst;
        reg_sel_t s1;
        reg_sel_t s2;
    } uop_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EXEC,
        S_CAPT,
        S_WALK,
        S_WSTEP,
        S_REB,
        S_OUT
    } ctl_state_t;

    typedef struct packed {
        ctl_state_t st;
        uop_t       uop;
        logic       load;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        func_t    func;
        variant_t variant;
        logic     walk_end;
        logic     reb_done;
        logic     bad;
    } sts_t;

    // Program entry points
    localparam pc_t PC_WRITE = 7'd0;
    localparam pc_t PC_DONE  = 7'd1;
    localparam pc_t PC_TWO   = 7'd2;
    localparam pc_t PC_THREE = 7'd11;
    localparam pc_t PC_V0    = 7'd20;
    localparam pc_t PC_V1    = 7'd32;
    localparam pc_t PC_V2    = 7'd44;
    localparam pc_t PC_V3    = 7'd58;

    function automatic uop_t u(op_t op, reg_sel_t d, reg_sel_t a, reg_sel_t b);
        uop_t r;
        r.op  = op;
        r.dst = d;
        r.s1  = a;
        r.s2  = b;
        return r;
    endfunction

    // Micro-program ROM. A distance op stores into the first count when dst
    // is the second city, into the second count when dst is the third city.
    function automatic uop_t prog(pc_t pc);
        uop_t r;
        case (pc)
            // write, then the shared read-out
            7'd0:  r = u(OP_WRITE,   R_C1, R_C1, R_C1);
            7'd1:  r = u(OP_DONE,    R_C1, R_C1, R_C1);
            // two-opt
            7'd2:  r = u(OP_HOP,     R_C2, R_C1, R_C1);
            7'd3:  r = u(OP_NX,      R_T,  R_C2, R_C1);
            7'd4:  r = u(OP_NX,      R_X,  R_C1, R_C1);
            7'd5:  r = u(OP_PUT,     R_C1, R_X,  R_T);
            7'd6:  r = u(OP_NX,      R_X,  R_C1, R_C1);
            7'd7:  r = u(OP_RELINK,  R_C1, R_C2, R_X);
            7'd8:  r = u(OP_PUT,     R_C1, R_C1, R_C2);
            7'd9:  r = u(OP_REBUILD, R_C1, R_C1, R_C1);
            7'd10: r = u(OP_DONE,    R_C1, R_C1, R_C1);
            // three-opt: find second city, gather neighbours, check, measure distances, order
            7'd11: r = u(OP_HOP,     R_C2, R_C1, R_C1);
            7'd12: r = u(OP_PR,      R_A,  R_C1, R_C1);
            7'd13: r = u(OP_NX,      R_B,  R_C1, R_C1);
            7'd14: r = u(OP_NX,      R_C,  R_C2, R_C1);
            7'd15: r = u(OP_PR,      R_T,  R_C2, R_C1);
            7'd16: r = u(OP_CHECK,   R_C1, R_C1, R_C1);
            7'd17: r = u(OP_DIST,    R_C2, R_C1, R_C2);
            7'd18: r = u(OP_DIST,    R_C3, R_C1, R_C3);
            7'd19: r = u(OP_ORDER,   R_C1, R_C1, R_C1);
            // reconnection with two reversed segments, closed from third to first
            7'd20: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd21: r = u(OP_NX,      R_X,  R_B,  R_C1);
            7'd22: r = u(OP_PUT,     R_C1, R_T,  R_X);
            7'd23: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd24: r = u(OP_RELINK,  R_C1, R_B,  R_T);
            7'd25: r = u(OP_NX,      R_T,  R_C,  R_C1);
            7'd26: r = u(OP_PUT,     R_C1, R_T,  R_B);
            7'd27: r = u(OP_NX,      R_T,  R_C,  R_C1);
            7'd28: r = u(OP_RELINK,  R_C1, R_A,  R_T);
            7'd29: r = u(OP_PUT,     R_C1, R_C,  R_A);
            7'd30: r = u(OP_REBUILD, R_C1, R_C1, R_C1);
            7'd31: r = u(OP_DONE,    R_C1, R_C1, R_C1);
            // reconnection with two reversed segments, first linked to second
            7'd32: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd33: r = u(OP_PUT,     R_C1, R_T,  R_C);
            7'd34: r = u(OP_NX,      R_T,  R_B,  R_C1);
            7'd35: r = u(OP_NX,      R_X,  R_C,  R_C1);
            7'd36: r = u(OP_PUT,     R_C1, R_T,  R_X);
            7'd37: r = u(OP_NX,      R_T,  R_B,  R_C1);
            7'd38: r = u(OP_RELINK,  R_C1, R_C,  R_T);
            7'd39: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd40: r = u(OP_RELINK,  R_C1, R_B,  R_T);
            7'd41: r = u(OP_PUT,     R_C1, R_A,  R_B);
            7'd42: r = u(OP_REBUILD, R_C1, R_C1, R_C1);
            7'd43: r = u(OP_DONE,    R_C1, R_C1, R_C1);
            // reconnection with all three segments reversed
            7'd44: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd45: r = u(OP_PUT,     R_C1, R_T,  R_C);
            7'd46: r = u(OP_NX,      R_T,  R_B,  R_C1);
            7'd47: r = u(OP_PUT,     R_C1, R_T,  R_A);
            7'd48: r = u(OP_NX,      R_T,  R_C,  R_C1);
            7'd49: r = u(OP_PUT,     R_C1, R_T,  R_B);
            7'd50: r = u(OP_NX,      R_X,  R_C,  R_C1);
            7'd51: r = u(OP_NX,      R_T,  R_B,  R_C1);
            7'd52: r = u(OP_RELINK,  R_C1, R_C,  R_T);
            7'd53: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd54: r = u(OP_RELINK,  R_C1, R_B,  R_T);
            7'd55: r = u(OP_RELINK,  R_C1, R_A,  R_X);
            7'd56: r = u(OP_REBUILD, R_C1, R_C1, R_C1);
            7'd57: r = u(OP_DONE,    R_C1, R_C1, R_C1);
            // reconnection with one reversed segment, first linked past it
            7'd58: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd59: r = u(OP_NX,      R_X,  R_C,  R_C1);
            7'd60: r = u(OP_PUT,     R_C1, R_T,  R_X);
            7'd61: r = u(OP_NX,      R_X,  R_B,  R_C1);
            7'd62: r = u(OP_NX,      R_T,  R_A,  R_C1);
            7'd63: r = u(OP_RELINK,  R_C1, R_B,  R_T);
            7'd64: r = u(OP_PUT,     R_C1, R_A,  R_X);
            7'd65: r = u(OP_PUT,     R_C1, R_C,  R_B);
            7'd66: r = u(OP_REBUILD, R_C1, R_C1, R_C1);
            7'd67: r = u(OP_DONE,    R_C1, R_C1, R_C1);
            default: r = u(OP_DONE,  R_C1, R_C1, R_C1);
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/ttom_req_if.sv
// Request channel interface: valid, ready and one request item.
`timescale 1ns / 1ps

interface ttom_req_if;
    import ttom_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ttom_rsp_if.sv
// Response channel interface: valid, ready and one result item.
`timescale 1ns / 1ps

interface ttom_rsp_if;
    import ttom_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tour_two_three_opt_move.sv
// Top level of the tour move block: controller, datapath and assertions.
//
// Holds a cyclic tour of 64 cities as successor and predecessor tables.
// Requests arrive on req (valid/ready); each transaction carries a write,
// read, two-opt or three-opt operation. Each request gives exactly one
// transaction on rsp with status and the successor and predecessor of city.
// A two-opt move walks forward hops steps, relinks one path and rebuilds
// the predecessor table; a three-opt move that passes its check adds two
// backward distance walks and up to three relink walks. Speed is bound by
// the single read port of each table: every walk step reads a table and
// then captures the read value, and the predecessor rebuild sweeps the
// successor table once per move that is carried out.
// One request is worked at a time; the next is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When rsp is stalled the result holds; a finished operation then waits.
// Reset clears the control state; table contents stay undefined until
// written.
`timescale 1ns / 1ps

module tour_two_three_opt_move (
    input  logic      clk,
    input  logic      rst_n,
    ttom_req_if.sink  req,
    ttom_rsp_if.source rsp
);
    import ttom_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ttom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ttom_datapath u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .req_data (req.data),
        .sts      (sts),
        .rsp_data (rsp.data)
    );

    // a new request is never taken twice in a row
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while a transaction is in progress");

    // the result register is only overwritten when free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp.valid || rsp.ready))
        else $error("pending result overwritten");

    // a result appears only after a result load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    // a rejected third city skips straight to the read-out
    a_reject_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.st == S_EXEC && cmd.uop.op == OP_CHECK && sts.bad) |=>
        (cmd.st == S_EXEC && cmd.uop.op == OP_DONE))
        else $error("rejected move did not go to read-out");

endmodule

>>> hw/rtl/ttom_datapath.sv
// Datapath: tour tables, working registers, walk counter and result register.
`timescale 1ns / 1ps

module ttom_datapath (
    input  logic               clk,
    input  ttom_pkg::cmd_t     cmd,
    input  ttom_pkg::req_item_t req_data,
    output ttom_pkg::sts_t     sts,
    output ttom_pkg::rsp_item_t rsp_data
);
    import ttom_pkg::*;

    // tour tables
    city_t succ_mem [CITIES];
    city_t pred_mem [CITIES];
    city_t succ_q_reg;
    city_t pred_q_reg;

    city_t c1_reg, c2_reg, c3_reg, a_reg, b_reg, cc_reg, t_reg, x_reg;
    city_t val_reg;
    logic [5:0] hops_reg;
    func_t func_reg;
    variant_t variant_reg;
    city_t wt_reg;
    cnt_t  cnt_reg;
    cnt_t  d1_reg, d2_reg;
    logic  status_reg;
    rsp_item_t rsp_reg;

    op_t   op;
    city_t s1v, s2v;
    logic  walk_end, bad, reb_done, swap;
    city_t succ_ra, pred_ra;
    logic  succ_we, pred_we;
    city_t succ_wa, succ_wd, pred_wa, pred_wd;
    logic  dst_we;
    city_t dst_val;

    assign op = cmd.uop.op;

    // operand selection
    always_comb
    begin
        case (cmd.uop.s1)
            R_C1:    s1v = c1_reg;
            R_C2:    s1v = c2_reg;
            R_C3:    s1v = c3_reg;
            R_A:     s1v = a_reg;
            R_B:     s1v = b_reg;
            R_C:     s1v = cc_reg;
            R_T:     s1v = t_reg;
            R_X:     s1v = x_reg;
            default: s1v = c1_reg;
        endcase
        case (cmd.uop.s2)
            R_C1:    s2v = c1_reg;
            R_C2:    s2v = c2_reg;
            R_C3:    s2v = c3_reg;
            R_A:     s2v = a_reg;
            R_B:     s2v = b_reg;
            R_C:     s2v = cc_reg;
            R_T:     s2v = t_reg;
            R_X:     s2v = x_reg;
            default: s2v = c1_reg;
        endcase
    end

    // walk termination: hop count, or target reached / full lap
    assign walk_end = (op == OP_HOP) ? (cnt_reg == CNT_W'(hops_reg))
                    : ((cnt_reg == CNT_W'(CITIES)) || (wt_reg == s2v));
    assign reb_done = (cnt_reg == CNT_W'(CITIES));
    // third city clashes with the first or second city or their neighbours
    assign bad = (c3_reg == c1_reg) || (c3_reg == a_reg) || (c3_reg == b_reg) ||
                 (c3_reg == c2_reg) || (c3_reg == cc_reg) || (c3_reg == t_reg);
    // larger backward step count means the nearer city in forward order
    assign swap = (d1_reg < d2_reg);

    // table addressing
    always_comb
    begin
        succ_ra = c1_reg;
        pred_ra = c1_reg;
        succ_we = 1'b0;
        succ_wa = c1_reg;
        succ_wd = val_reg;
        pred_we = 1'b0;
        pred_wa = val_reg;
        pred_wd = c1_reg;
        case (cmd.st)
            S_EXEC:
            begin
                succ_ra = s1v;
                pred_ra = s1v;
                if (op == OP_WRITE)
                begin
                    succ_we = 1'b1;
                    pred_we = 1'b1;
                end
                else if (op == OP_PUT)
                begin
                    succ_we = 1'b1;
                    succ_wa = s1v;
                    succ_wd = s2v;
                end
            end
            S_WALK:
            begin
                succ_ra = wt_reg;
                pred_ra = wt_reg;
            end
            S_WSTEP:
            begin
                if (op == OP_RELINK)
                begin
                    succ_we = 1'b1;
                    succ_wa = wt_reg;
                    succ_wd = pred_q_reg;
                end
            end
            S_REB:
            begin
                succ_ra = cnt_reg[IDX_W-1:0];
                if (cnt_reg != '0)
                begin
                    pred_we = 1'b1;
                    pred_wa = succ_q_reg;
                    pred_wd = IDX_W'(cnt_reg - CNT_W'(1));
                end
            end
            default:
            begin
                succ_ra = c1_reg;
                pred_ra = c1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (succ_we)
        begin
            succ_mem[succ_wa] <= succ_wd;
        end
        succ_q_reg <= succ_mem[succ_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pred_we)
        begin
            pred_mem[pred_wa] <= pred_wd;
        end
        pred_q_reg <= pred_mem[pred_ra];
    end

    // destination write of a working register
    always_comb
    begin
        dst_we  = 1'b0;
        dst_val = succ_q_reg;
        if (cmd.st == S_CAPT)
        begin
            dst_we  = 1'b1;
            dst_val = (op == OP_PR) ? pred_q_reg : succ_q_reg;
        end
        else if (cmd.st == S_WALK && walk_end && op == OP_HOP)
        begin
            dst_we  = 1'b1;
            dst_val = wt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c1_reg      <= req_data.city;
            c3_reg      <= req_data.third_city;
            val_reg     <= req_data.next_city;
            hops_reg    <= req_data.hops;
            func_reg    <= func_t'(req_data.func);
            variant_reg <= variant_t'(req_data.variant);
        end
        else if (cmd.st == S_EXEC && op == OP_ORDER)
        begin
            a_reg  <= c1_reg;
            b_reg  <= swap ? c3_reg : c2_reg;
            cc_reg <= swap ? c2_reg : c3_reg;
        end
        else if (dst_we)
        begin
            case (cmd.uop.dst)
                R_C1:    c1_reg <= dst_val;
                R_C2:    c2_reg <= dst_val;
                R_C3:    c3_reg <= dst_val;
                R_A:     a_reg  <= dst_val;
                R_B:     b_reg  <= dst_val;
                R_C:     cc_reg <= dst_val;
                R_T:     t_reg  <= dst_val;
                R_X:     x_reg  <= dst_val;
                default: t_reg  <= dst_val;
            endcase
        end
    end

    // walk pointer and step counter, also the rebuild index
    always_ff @(posedge clk)
    begin
        if (cmd.st == S_EXEC &&
            (op == OP_HOP || op == OP_RELINK || op == OP_DIST || op == OP_REBUILD))
        begin
            wt_reg  <= s1v;
            cnt_reg <= '0;
        end
        else if (cmd.st == S_WSTEP)
        begin
            wt_reg  <= (op == OP_HOP) ? succ_q_reg : pred_q_reg;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.st == S_REB && !reb_done)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // backward distances
    always_ff @(posedge clk)
    begin
        if (cmd.st == S_WALK && walk_end && op == OP_DIST)
        begin
            if (cmd.uop.dst == R_C3)
            begin
                d2_reg <= cnt_reg;
            end
            else
            begin
                d1_reg <= cnt_reg;
            end
        end
    end

    // status and result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= 1'b0;
        end
        else if (cmd.st == S_EXEC && op == OP_CHECK && bad)
        begin
            status_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status   <= status_reg;
            rsp_reg.succ_out <= succ_q_reg;
            rsp_reg.pred_out <= pred_q_reg;
        end
    end

    assign rsp_data     = rsp_reg;
    assign sts.func     = func_reg;
    assign sts.variant  = variant_reg;
    assign sts.walk_end = walk_end;
    assign sts.reb_done = reb_done;
    assign sts.bad      = bad;

endmodule

>>> hw/rtl/ttom_ctrl.sv
// Controller: state machine and micro-program counter of the tour move block.
`timescale 1ns / 1ps

module ttom_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  ttom_pkg::sts_t sts,
    output ttom_pkg::cmd_t cmd
);
    import ttom_pkg::*;

    ctl_state_t state_reg, state_next;
    pc_t        pc_reg, pc_next;
    logic       rsp_valid_reg, rsp_valid_next;
    uop_t       uop;
    logic       out_load;

    assign uop = prog(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PC_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state, program counter and result hand-off
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_EXEC;
                case (sts.func)
                    FN_WRITE:     pc_next = PC_WRITE;
                    FN_TWO_OPT:   pc_next = PC_TWO;
                    FN_THREE_OPT: pc_next = PC_THREE;
                    FN_READ:      pc_next = PC_DONE;
                    default:      pc_next = PC_DONE;
                endcase
            end
            S_EXEC:
            begin
                case (uop.op)
                    OP_NX, OP_PR:
                    begin
                        state_next = S_CAPT;
                    end
                    OP_HOP, OP_RELINK, OP_DIST:
                    begin
                        state_next = S_WALK;
                    end
                    OP_CHECK:
                    begin
                        pc_next = sts.bad ? PC_DONE : pc_reg + PC_W'(1);
                    end
                    OP_ORDER:
                    begin
                        case (sts.variant)
                            VAR_CASE0: pc_next = PC_V0;
                            VAR_CASE1: pc_next = PC_V1;
                            VAR_CASE2: pc_next = PC_V2;
                            VAR_CASE3: pc_next = PC_V3;
                            default:   pc_next = PC_V0;
                        endcase
                    end
                    OP_REBUILD:
                    begin
                        state_next = S_REB;
                    end
                    OP_DONE:
                    begin
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                endcase
            end
            S_CAPT:
            begin
                pc_next    = pc_reg + PC_W'(1);
                state_next = S_EXEC;
            end
            S_WALK:
            begin
                if (sts.walk_end)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_WSTEP;
                end
            end
            S_WSTEP:
            begin
                state_next = S_WALK;
            end
            S_REB:
            begin
                if (sts.reb_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_EXEC;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign cmd.st       = state_reg;
    assign cmd.uop      = uop;
    assign cmd.load     = (state_reg == S_IDLE) && req_valid;
    assign cmd.out_load = out_load;

endmodule

>>> dv/tour_two_three_opt_move_test.sv
// Testbench for the tour move block: directed and random write, read and move transactions.
`timescale 1ns / 1ps

module tour_two_three_opt_move_test;
    import ttom_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   failed = 1'b0;

    ttom_req_if req ();
    ttom_rsp_if rsp ();

    tour_two_three_opt_move DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #2 clk = ~clk;

    // Shadow copy of the tour
    city_t succ_tab [CITIES];
    city_t pred_tab [CITIES];
    rsp_item_t tour_answers [$];
    bit    rsp_stall_on = 1'b1;

    function automatic city_t step_fwd(city_t c);
        return succ_tab[c];
    endfunction

    // Walk backward through old predecessors, relinking, until the end city
    function automatic void relink_back(city_t t, city_t stop);
        city_t p;
        for (int n = 0; n < CITIES && t != stop; n++)
        begin
            p = pred_tab[t];
            succ_tab[t] = p;
            t = p;
        end
    endfunction

    function automatic int back_steps(city_t t, city_t target);
        int n;
        n = 0;
        while (n < CITIES && t != target)
        begin
            t = pred_tab[t];
            n++;
        end
        return n;
    endfunction

    function automatic void rebuild_preds();
        for (int i = 0; i < CITIES; i++)
            pred_tab[succ_tab[i]] = city_t'(i);
    endfunction

    function automatic void apply_case(city_t a, city_t b, city_t c, variant_t v);
        city_t t;
        case (v)
            VAR_CASE0:
            begin
                succ_tab[step_fwd(a)] = step_fwd(b);
                relink_back(b, step_fwd(a));
                succ_tab[step_fwd(c)] = b;
                relink_back(a, step_fwd(c));
                succ_tab[c] = a;
            end
            VAR_CASE1:
            begin
                succ_tab[step_fwd(a)] = c;
                succ_tab[step_fwd(b)] = step_fwd(c);
                relink_back(c, step_fwd(b));
                relink_back(b, step_fwd(a));
                succ_tab[a] = b;
            end
            VAR_CASE2:
            begin
                succ_tab[step_fwd(a)] = c;
                succ_tab[step_fwd(b)] = a;
                succ_tab[step_fwd(c)] = b;
                t = step_fwd(c);
                relink_back(c, step_fwd(b));
                relink_back(b, step_fwd(a));
                relink_back(a, t);
            end
            default:
            begin
                succ_tab[step_fwd(a)] = step_fwd(c);
                t = step_fwd(b);
                relink_back(b, step_fwd(a));
                succ_tab[a] = t;
                succ_tab[c] = b;
            end
        endcase
    endfunction

    // Predict the response of one request and update the shadow tour
    function automatic rsp_item_t predict_move(req_item_t r);
        rsp_item_t o;
        city_t c1, c2, c3, b;
        bit bad;
        c1 = r.city;
        c3 = r.third_city;
        c2 = c1;
        o.status = 1'b0;
        if (r.func == FN_TWO_OPT || r.func == FN_THREE_OPT)
            for (int i = 0; i < r.hops; i++)
                c2 = step_fwd(c2);
        case (func_t'(r.func))
            FN_WRITE:
            begin
                succ_tab[c1] = r.next_city;
                pred_tab[r.next_city] = c1;
            end
            FN_TWO_OPT:
            begin
                b = step_fwd(c2);
                succ_tab[step_fwd(c1)] = b;
                relink_back(c2, step_fwd(c1));
                succ_tab[c1] = c2;
                rebuild_preds();
            end
            FN_THREE_OPT:
            begin
                bad = c3 == c1 || c3 == pred_tab[c1] || c3 == step_fwd(c1) ||
                      c3 == c2 || c3 == step_fwd(c2) || c3 == pred_tab[c2];
                if (bad)
                    o.status = 1'b1;
                else
                begin
                    if (CITIES - back_steps(c1, c2) <= CITIES - back_steps(c1, c3))
                        apply_case(c1, c2, c3, variant_t'(r.variant));
                    else
                        apply_case(c1, c3, c2, variant_t'(r.variant));
                    rebuild_preds();
                end
            end
            default: ;
        endcase
        o.succ_out = succ_tab[c1];
        o.pred_out = pred_tab[c1];
        return o;
    endfunction

    // Send one request after a random gap; valid stays high into a gapless next request
    task automatic send_req(req_item_t r);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        tour_answers.push_back(predict_move(r));
        @(negedge clk);
    endtask

    function automatic req_item_t mk(func_t f, city_t c, city_t n, logic [5:0] h,
                                     city_t t, variant_t v);
        req_item_t r;
        r.func = f;
        r.city = c;
        r.next_city = n;
        r.hops = h;
        r.third_city = t;
        r.variant = v;
        return r;
    endfunction

    // Load a tour: identity order, or a random permutation
    task automatic load_tour(bit shuffle);
        int perm [CITIES];
        int j, tmp;
        for (int i = 0; i < CITIES; i++) perm[i] = i;
        if (shuffle)
            for (int i = CITIES - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
            end
        for (int i = 0; i < CITIES; i++)
            send_req(mk(FN_WRITE, city_t'(perm[i]), city_t'(perm[(i + 1) % CITIES]), 6'd0,
                        city_t'($urandom), variant_t'($urandom)));
    endtask

    function automatic req_item_t rand_move();
        req_item_t r;
        r = mk(func_t'($urandom_range(1, 2)), city_t'($urandom), city_t'($urandom),
               6'($urandom_range(2, 62)), city_t'($urandom), variant_t'($urandom));
        if ($urandom_range(0, 19) == 0) r.hops = 6'($urandom);
        return r;
    endfunction

    task automatic test_field_extremes();
        load_tour(1'b0);
        send_req(mk(FN_READ, 6'd0, 6'd63, 6'd63, 6'd63, VAR_CASE3));
        send_req(mk(FN_READ, 6'd63, 6'd0, 6'd0, 6'd0, VAR_CASE0));
        send_req(mk(FN_TWO_OPT, 6'd0, 6'd0, 6'd2, 6'd0, VAR_CASE0));
        send_req(mk(FN_TWO_OPT, 6'd63, 6'd63, 6'd62, 6'd63, VAR_CASE0));
        send_req(mk(FN_TWO_OPT, 6'd5, 6'd0, 6'd0, 6'd0, VAR_CASE0));
        send_req(mk(FN_TWO_OPT, 6'd9, 6'd0, 6'd63, 6'd0, VAR_CASE0));
        send_req(mk(FN_TWO_OPT, 6'd9, 6'd0, 6'd1, 6'd0, VAR_CASE0));
    endtask

    task automatic test_three_opt_cases();
        load_tour(1'b0);
        for (int v = 0; v < 4; v++)
        begin
            send_req(mk(FN_THREE_OPT, 6'd0, 6'd0, 6'd10, 6'd40, variant_t'(v)));
            send_req(mk(FN_THREE_OPT, 6'd3, 6'd0, 6'd40, 6'd20, variant_t'(v)));
        end
        // clash checks: the third city equals the first city, then a further candidate
        send_req(mk(FN_THREE_OPT, 6'd7, 6'd0, 6'd4, 6'd7, VAR_CASE0));
        send_req(mk(FN_THREE_OPT, 6'd7, 6'd0, 6'd4, 6'd63, VAR_CASE1));
        send_req(mk(FN_READ, 6'd7, 6'd0, 6'd0, 6'd0, VAR_CASE0));
    endtask

    task automatic test_broken_tour();
        // overwrite some links so the tables no longer form one cycle
        for (int i = 0; i < 6; i++)
            send_req(mk(FN_WRITE, city_t'($urandom), city_t'($urandom), 6'd0, 6'd0,
                        VAR_CASE0));
        for (int i = 0; i < 30; i++) send_req(rand_move());
    endtask

    task automatic test_random_moves();
        int k;
        for (int tour = 0; tour < 6; tour++)
        begin
            load_tour(1'b1);
            for (int i = 0; i < 165; i++)
            begin
                k = $urandom_range(0, 9);
                if (k == 0)
                    send_req(mk(FN_READ, city_t'($urandom), city_t'($urandom),
                                6'($urandom), city_t'($urandom), variant_t'($urandom)));
                else
                    send_req(rand_move());
            end
            if (tour == 2) rsp_stall_on = 1'b0;
            if (tour == 4) rsp_stall_on = 1'b1;
        end
        test_broken_tour();
    endtask

    // Response side: random stalls while enabled, compare with oldest prediction
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            gap = rsp_stall_on ? $urandom_range(0, 7) : 0;
            if (gap != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
            if (tour_answers.size() == 0)
            begin
                $error("unexpected transaction: %p", rsp.data);
                failed = 1'b1;
            end
            else
            begin : compare
                rsp_item_t e;
                e = tour_answers.pop_front();
                if (rsp.data.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.data.status);
                    failed = 1'b1;
                end
                if (rsp.data.succ_out !== e.succ_out)
                begin
                    $error("succ_out: expected %0d, got %0d", e.succ_out, rsp.data.succ_out);
                    failed = 1'b1;
                end
                if (rsp.data.pred_out !== e.pred_out)
                begin
                    $error("pred_out: expected %0d, got %0d", e.pred_out, rsp.data.pred_out);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_field_extremes();
        test_three_opt_cases();
        test_random_moves();
        req.valid <= 1'b0;
        while (tour_answers.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (!failed)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> tour_two_three_opt_move.f
hw/rtl/ttom_pkg.sv
hw/rtl/ttom_req_if.sv
hw/rtl/ttom_rsp_if.sv
hw/rtl/ttom_datapath.sv
hw/rtl/ttom_ctrl.sv
hw/rtl/tour_two_three_opt_move.sv
dv/tour_two_three_opt_move_test.sv
